// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define TSR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// checked at every edge, reset included
`define TSR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== src/tsrsm_pkg.sv =====
// package for the two-stack radix sort move unit
// beat types, function, move and phase codes, sizes; no dependencies
`default_nettype none
package tsrsm_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(MAX_ITEMS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int PASS_W     = 3;

  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_FETCH = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;
  localparam logic [1:0] FN_SPARE = 2'd3;

  localparam logic [2:0] MV_NONE = 3'd0;
  localparam logic [2:0] MV_PB   = 3'd1;
  localparam logic [2:0] MV_RA   = 3'd2;
  localparam logic [2:0] MV_PA   = 3'd3;
  localparam logic [2:0] MV_RB   = 3'd4;

  localparam logic [2:0] PH_LOADING = 3'd0;
  localparam logic [2:0] PH_PASS_A  = 3'd1;
  localparam logic [2:0] PH_PASS_B  = 3'd2;
  localparam logic [2:0] PH_DRAIN   = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  typedef struct packed {
    logic [1:0]                   func;
    logic signed [VALUE_BITS-1:0] value;
  } in_t;

  typedef struct packed {
    logic [2:0] move;
    logic       done_res;
    logic       error;
  } out_t;

endpackage
`default_nettype wire

// ===== src/two_stack_radix_sort_moves_unit.sv =====
// two-stack radix sort move unit: value store, two rank stacks, sequencer
// depends on tsrsm_pkg
// a load scans the value memory for a duplicate, one read a cycle;
//   the first fetch ranks every item first, each rank being one more scan of the value memory
// one item at a time: busy stays high until the result strobe
// results are shown for one cycle on out_valid, the receiver cannot stall
// synchronous active-low reset clears all control state; memories are not cleared
`default_nettype none
module two_stack_radix_sort_moves_unit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire tsrsm_pkg::in_t in_data,
  output logic                out_valid,
  output tsrsm_pkg::out_t     out_data
);

  localparam int IW = tsrsm_pkg::IDX_W;
  localparam int CW = tsrsm_pkg::CNT_W;
  localparam int PW = tsrsm_pkg::PASS_W;
  localparam int VB = tsrsm_pkg::VALUE_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_RK_I = 4'd3;
  localparam logic [3:0] S_RK_V = 4'd4;
  localparam logic [3:0] S_MV   = 4'd5;
  localparam logic [3:0] S_MV_A = 4'd6;
  localparam logic [3:0] S_MV_B = 4'd7;
  localparam logic [3:0] S_MV_D = 4'd8;

  logic [VB-1:0] raw_mem [tsrsm_pkg::MAX_ITEMS];
  logic [IW-1:0] a_mem   [tsrsm_pkg::MAX_ITEMS];
  logic [IW-1:0] b_mem   [tsrsm_pkg::MAX_ITEMS];

  logic [VB-1:0] raw_rd_r;
  logic [IW-1:0] a_rd_r, b_rd_r;
  logic [IW-1:0] raw_ra, a_ra, b_ra, raw_wa, a_wa, b_wa;
  logic [VB-1:0] raw_wd;
  logic [IW-1:0] a_wd, b_wd;
  logic          raw_we, a_we, b_we;

  logic [3:0]    state_r, state_nxt;
  tsrsm_pkg::in_t in_r, in_nxt;
  logic [VB-1:0] key_r, key_nxt;
  logic [CW-1:0] j_r, j_nxt, i_r, i_nxt, rank_r, rank_nxt;
  logic          cmp_v_r, cmp_v_nxt, dup_r, dup_nxt, rank_mode_r, rank_mode_nxt;
  logic [IW-1:0] a_head_r, a_head_nxt, b_head_r, b_head_nxt;
  logic [CW-1:0] a_count_r, a_count_nxt, b_count_r, b_count_nxt;
  logic [CW-1:0] item_count_r, item_count_nxt, loop_left_r, loop_left_nxt;
  logic [PW-1:0] pass_bit_r, pass_bit_nxt, pass_total_r, pass_total_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic          error_r, error_nxt;
  logic          out_valid_r, out_valid_nxt;
  tsrsm_pkg::out_t out_data_r, out_data_nxt;
  logic [CW-1:0] nm1;
  logic [PW-1:0] bits_c;
  logic [PW:0]   pb_inc;

  always_ff @(posedge clk) begin
    raw_rd_r <= raw_mem[raw_ra];
    a_rd_r   <= a_mem[a_ra];
    b_rd_r   <= b_mem[b_ra];
    if (raw_we) raw_mem[raw_wa] <= raw_wd;
    if (a_we) a_mem[a_wa] <= a_wd;
    if (b_we) b_mem[b_wa] <= b_wd;
  end

  // pass count = bit length of n-1
  always_comb begin
    nm1    = item_count_r - CW'(1);
    bits_c = '0;
    for (int k = 0; k < CW; k++) begin
      if ((nm1 >> k) != '0) bits_c = PW'(k + 1);
    end
  end

  assign pb_inc = {1'b0, pass_bit_r} + (PW+1)'(1);

  always_comb begin
    state_nxt      = state_r;
    in_nxt         = in_r;
    key_nxt        = key_r;
    j_nxt          = j_r;
    i_nxt          = i_r;
    rank_nxt       = rank_r;
    cmp_v_nxt      = 1'b0;
    dup_nxt        = dup_r;
    rank_mode_nxt  = rank_mode_r;
    a_head_nxt     = a_head_r;
    b_head_nxt     = b_head_r;
    a_count_nxt    = a_count_r;
    b_count_nxt    = b_count_r;
    item_count_nxt = item_count_r;
    loop_left_nxt  = loop_left_r;
    pass_bit_nxt   = pass_bit_r;
    pass_total_nxt = pass_total_r;
    phase_nxt      = phase_r;
    error_nxt      = error_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    raw_ra = j_r[IW-1:0];
    a_ra   = a_head_r;
    b_ra   = b_head_r;
    raw_we = 1'b0; raw_wa = item_count_r[IW-1:0]; raw_wd = key_r;
    a_we   = 1'b0; a_wa = i_r[IW-1:0];            a_wd = rank_r[IW-1:0];
    b_we   = 1'b0; b_wa = b_head_r - IW'(1);      b_wd = a_rd_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          in_nxt    = in_data;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        out_data_nxt.move     = tsrsm_pkg::MV_NONE;
        out_data_nxt.done_res = 1'b0;
        out_data_nxt.error    = error_r;
        case (in_r.func)
          tsrsm_pkg::FN_LOAD: begin
            if (phase_r == tsrsm_pkg::PH_LOADING) begin
              key_nxt       = {~in_r.value[VB-1], in_r.value[VB-2:0]};
              j_nxt         = '0;
              dup_nxt       = 1'b0;
              rank_mode_nxt = 1'b0;
              state_nxt     = S_SCAN;
            end else begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          tsrsm_pkg::FN_FETCH: begin
            if (error_r) begin
              out_data_nxt.done_res = 1'b1;
              out_valid_nxt         = 1'b1;
              state_nxt             = S_IDLE;
            end else if (phase_r == tsrsm_pkg::PH_LOADING) begin
              if (item_count_r <= CW'(3)) begin
                phase_nxt = tsrsm_pkg::PH_DONE;
                state_nxt = S_MV;
              end else begin
                i_nxt     = '0;
                state_nxt = S_RK_I;
              end
            end else begin
              state_nxt = S_MV;
            end
          end
          tsrsm_pkg::FN_CLEAR: begin
            a_head_nxt = '0; b_head_nxt = '0; a_count_nxt = '0; b_count_nxt = '0;
            item_count_nxt = '0; loop_left_nxt = '0;
            pass_bit_nxt = '0; pass_total_nxt = '0;
            phase_nxt = tsrsm_pkg::PH_LOADING;
            error_nxt = 1'b0;
            out_data_nxt.error = 1'b0;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
          default: begin
            out_data_nxt.done_res = (phase_r == tsrsm_pkg::PH_DONE);
            out_valid_nxt         = 1'b1;
            state_nxt             = S_IDLE;
          end
        endcase
      end
      // one memory read issued a cycle, compare on the registered data
      S_SCAN: begin
        if (cmp_v_r) begin
          if (rank_mode_r) begin
            if (raw_rd_r < key_r) rank_nxt = rank_r + CW'(1);
          end else if (raw_rd_r == key_r) begin
            dup_nxt = 1'b1;
          end
        end
        if (j_r < item_count_r) begin
          j_nxt     = j_r + CW'(1);
          cmp_v_nxt = 1'b1;
        end else if (!cmp_v_r) begin
          if (rank_mode_r) begin
            a_we  = 1'b1;
            i_nxt = i_r + CW'(1);
            if (i_r + CW'(1) == item_count_r) begin
              a_head_nxt     = '0;
              a_count_nxt    = item_count_r;
              b_head_nxt     = '0;
              b_count_nxt    = '0;
              pass_total_nxt = bits_c;
              pass_bit_nxt   = '0;
              loop_left_nxt  = item_count_r;
              phase_nxt      = tsrsm_pkg::PH_PASS_A;
              state_nxt      = S_MV;
            end else begin
              state_nxt = S_RK_I;
            end
          end else begin
            if (dup_r || item_count_r >= CW'(tsrsm_pkg::MAX_ITEMS)) begin
              error_nxt = 1'b1;
              out_data_nxt.error = 1'b1;
            end else begin
              raw_we         = 1'b1;
              item_count_nxt = item_count_r + CW'(1);
            end
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_RK_I: begin
        raw_ra    = i_r[IW-1:0];
        state_nxt = S_RK_V;
      end
      S_RK_V: begin
        key_nxt       = raw_rd_r;
        j_nxt         = '0;
        rank_nxt      = '0;
        rank_mode_nxt = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_MV: begin
        case (phase_r)
          tsrsm_pkg::PH_PASS_A: begin
            if (loop_left_r == '0 || a_count_r == '0) begin
              if (pb_inc < {1'b0, pass_total_r}) begin
                phase_nxt     = tsrsm_pkg::PH_PASS_B;
                loop_left_nxt = b_count_r;
              end else begin
                phase_nxt = tsrsm_pkg::PH_DRAIN;
              end
            end else begin
              state_nxt = S_MV_A;
            end
          end
          tsrsm_pkg::PH_PASS_B, tsrsm_pkg::PH_DRAIN: begin
            if ((phase_r == tsrsm_pkg::PH_PASS_B && loop_left_r == '0) ||
                b_count_r == '0) begin
              pass_bit_nxt = pb_inc[PW-1:0];
              if (pb_inc < {1'b0, pass_total_r}) begin
                phase_nxt     = tsrsm_pkg::PH_PASS_A;
                loop_left_nxt = a_count_r;
              end else begin
                phase_nxt = tsrsm_pkg::PH_DONE;
              end
            end else if (phase_r == tsrsm_pkg::PH_PASS_B) begin
              state_nxt = S_MV_B;
            end else begin
              state_nxt = S_MV_D;
            end
          end
          default: begin
            phase_nxt             = tsrsm_pkg::PH_DONE;
            out_data_nxt.move     = tsrsm_pkg::MV_NONE;
            out_data_nxt.done_res = 1'b1;
            out_valid_nxt         = 1'b1;
            state_nxt             = S_IDLE;
          end
        endcase
      end
      S_MV_A: begin
        loop_left_nxt = loop_left_r - CW'(1);
        a_head_nxt    = a_head_r + IW'(1);
        if (a_rd_r[pass_bit_r] == 1'b0) begin
          a_count_nxt = a_count_r - CW'(1);
          b_head_nxt  = b_head_r - IW'(1);
          b_count_nxt = b_count_r + CW'(1);
          b_we        = 1'b1;
          out_data_nxt.move = tsrsm_pkg::MV_PB;
        end else begin
          a_we = 1'b1;
          a_wa = a_head_r + a_count_r[IW-1:0];
          a_wd = a_rd_r;
          out_data_nxt.move = tsrsm_pkg::MV_RA;
        end
        out_data_nxt.done_res = 1'b0;
        out_valid_nxt         = 1'b1;
        state_nxt             = S_IDLE;
      end
      S_MV_B, S_MV_D: begin
        // pass b tests the next bit up; drain always pushes back to a
        if (state_r == S_MV_D || ((({1'b0, b_rd_r}) >> pb_inc) & (IW+1)'(1)) != '0) begin
          b_head_nxt  = b_head_r + IW'(1);
          b_count_nxt = b_count_r - CW'(1);
          a_head_nxt  = a_head_r - IW'(1);
          a_count_nxt = a_count_r + CW'(1);
          a_we = 1'b1;
          a_wa = a_head_r - IW'(1);
          a_wd = b_rd_r;
          out_data_nxt.move = tsrsm_pkg::MV_PA;
        end else begin
          b_head_nxt = b_head_r + IW'(1);
          b_we = 1'b1;
          b_wa = b_head_r + b_count_r[IW-1:0];
          b_wd = b_rd_r;
          out_data_nxt.move = tsrsm_pkg::MV_RB;
        end
        if (state_r == S_MV_B) loop_left_nxt = loop_left_r - CW'(1);
        out_data_nxt.done_res = 1'b0;
        out_valid_nxt         = 1'b1;
        state_nxt             = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cmp_v_r      <= 1'b0;
      dup_r        <= 1'b0;
      rank_mode_r  <= 1'b0;
      a_head_r     <= '0;
      b_head_r     <= '0;
      a_count_r    <= '0;
      b_count_r    <= '0;
      item_count_r <= '0;
      loop_left_r  <= '0;
      pass_bit_r   <= '0;
      pass_total_r <= '0;
      phase_r      <= tsrsm_pkg::PH_LOADING;
      error_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      j_r          <= '0;
      i_r          <= '0;
      rank_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      cmp_v_r      <= cmp_v_nxt;
      dup_r        <= dup_nxt;
      rank_mode_r  <= rank_mode_nxt;
      a_head_r     <= a_head_nxt;
      b_head_r     <= b_head_nxt;
      a_count_r    <= a_count_nxt;
      b_count_r    <= b_count_nxt;
      item_count_r <= item_count_nxt;
      loop_left_r  <= loop_left_nxt;
      pass_bit_r   <= pass_bit_nxt;
      pass_total_r <= pass_total_nxt;
      phase_r      <= phase_nxt;
      error_r      <= error_nxt;
      out_valid_r  <= out_valid_nxt;
      j_r          <= j_nxt;
      i_r          <= i_nxt;
      rank_r       <= rank_nxt;
    end
    in_r       <= in_nxt;
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== src/tsrsm_checker.sv =====
// port-level checker for the two-stack radix sort move unit, bound to the unit
// depends on tsrsm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module tsrsm_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            start,
  input wire logic            busy,
  input wire tsrsm_pkg::out_t out_data,
  input wire logic            out_valid
);

  logic real_move;

  assign real_move = out_valid && (out_data.move != tsrsm_pkg::MV_NONE);

  `TSR_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !busy && !out_valid)
  `TSR_ASSERT(a_accept_busy, clk, rst_n, start && !busy |=> busy)
  `TSR_ASSERT(a_result_idle, clk, rst_n, out_valid |-> !busy)
  `TSR_ASSERT(a_move_code, clk, rst_n, out_valid |-> out_data.move <= tsrsm_pkg::MV_RB)
  // a real move never comes with done or error
  `TSR_ASSERT(a_move_clean, clk, rst_n, real_move |-> !out_data.done_res && !out_data.error)

endmodule

bind two_stack_radix_sort_moves_unit tsrsm_checker u_tsrsm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_data  (out_data),
  .out_valid (out_valid)
);
`default_nettype wire

// ===== test/testbench.sv =====
// testbench for the two-stack radix sort move unit: directed and random command streams
// predicts every result with its own sort sequencer; depends on tsrsm_pkg and the unit
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int VB   = tsrsm_pkg::VALUE_BITS;
  localparam int NMAX = tsrsm_pkg::MAX_ITEMS;
  localparam int IW   = tsrsm_pkg::IDX_W;

  class move_scoreboard;
    logic [VB-1:0] keys [NMAX];
    logic [IW-1:0] rank_a [NMAX];
    logic [IW-1:0] rank_b [NMAX];
    int unsigned top_a, depth_a, top_b, depth_b, loaded, bit_no, bit_total, scan_left;
    logic [2:0] stage;
    bit sticky_err;
    tsrsm_pkg::out_t pending [$];
    int errors;

    function void clear_all();
      top_a = 0; depth_a = 0; top_b = 0; depth_b = 0; loaded = 0;
      bit_no = 0; bit_total = 0; scan_left = 0;
      stage = tsrsm_pkg::PH_LOADING;
      sticky_err = 0;
    endfunction

    function void shift_a_to_b();
      top_b = (top_b + NMAX - 1) % NMAX;
      rank_b[top_b] = rank_a[top_a];
      top_a = (top_a + 1) % NMAX;
      depth_a--; depth_b++;
    endfunction

    function void shift_b_to_a();
      top_a = (top_a + NMAX - 1) % NMAX;
      rank_a[top_a] = rank_b[top_b];
      top_b = (top_b + 1) % NMAX;
      depth_b--; depth_a++;
    endfunction

    function void next_bit();
      bit_no++;
      if (bit_no < bit_total) begin
        stage = tsrsm_pkg::PH_PASS_A;
        scan_left = depth_a;
      end else begin
        stage = tsrsm_pkg::PH_DONE;
      end
    endfunction

    function void rank_all();
      int unsigned r;
      for (int i = 0; i < loaded; i++) begin
        r = 0;
        for (int j = 0; j < loaded; j++)
          if (keys[j] < keys[i]) r++;
        rank_a[i] = IW'(r);
      end
      top_a = 0; depth_a = loaded; top_b = 0; depth_b = 0;
      bit_total = 0;
      while (bit_total < 32 && ((loaded - 1) >> bit_total) != 0) bit_total++;
      bit_no = 0;
      scan_left = depth_a;
      stage = tsrsm_pkg::PH_PASS_A;
    endfunction

    function logic [2:0] sort_step();
      forever begin
        case (stage)
          tsrsm_pkg::PH_PASS_A: begin
            if (scan_left == 0 || depth_a == 0) begin
              if (bit_no + 1 < bit_total) begin
                stage = tsrsm_pkg::PH_PASS_B;
                scan_left = depth_b;
              end else begin
                stage = tsrsm_pkg::PH_DRAIN;
              end
            end else begin
              scan_left--;
              if (rank_a[top_a][bit_no] == 1'b0) begin
                shift_a_to_b();
                return tsrsm_pkg::MV_PB;
              end
              rank_a[(top_a + depth_a) % NMAX] = rank_a[top_a];
              top_a = (top_a + 1) % NMAX;
              return tsrsm_pkg::MV_RA;
            end
          end
          tsrsm_pkg::PH_PASS_B: begin
            if (scan_left == 0 || depth_b == 0) begin
              next_bit();
            end else begin
              scan_left--;
              if (rank_b[top_b][bit_no + 1] == 1'b1) begin
                shift_b_to_a();
                return tsrsm_pkg::MV_PA;
              end
              rank_b[(top_b + depth_b) % NMAX] = rank_b[top_b];
              top_b = (top_b + 1) % NMAX;
              return tsrsm_pkg::MV_RB;
            end
          end
          tsrsm_pkg::PH_DRAIN: begin
            if (depth_b == 0) begin
              next_bit();
            end else begin
              shift_b_to_a();
              return tsrsm_pkg::MV_PA;
            end
          end
          default: begin
            stage = tsrsm_pkg::PH_DONE;
            return tsrsm_pkg::MV_NONE;
          end
        endcase
      end
    endfunction

    // predicts the result of one accepted beat and queues it
    function tsrsm_pkg::out_t note_command(tsrsm_pkg::in_t cmd);
      tsrsm_pkg::out_t r;
      logic [VB-1:0] key;
      bit dup;
      r = '0;
      case (cmd.func)
        tsrsm_pkg::FN_LOAD: begin
          if (stage == tsrsm_pkg::PH_LOADING) begin
            key = {~cmd.value[VB-1], cmd.value[VB-2:0]};
            dup = 0;
            for (int i = 0; i < loaded; i++)
              if (keys[i] == key) dup = 1;
            if (dup || loaded >= NMAX) sticky_err = 1;
            else keys[loaded++] = key;
          end
        end
        tsrsm_pkg::FN_FETCH: begin
          if (sticky_err) begin
            r.done_res = 1;
          end else begin
            if (stage == tsrsm_pkg::PH_LOADING) begin
              if (loaded <= 3) stage = tsrsm_pkg::PH_DONE;
              else rank_all();
            end
            r.move = sort_step();
            r.done_res = (r.move == tsrsm_pkg::MV_NONE);
          end
        end
        tsrsm_pkg::FN_CLEAR: clear_all();
        default: r.done_res = (stage == tsrsm_pkg::PH_DONE);
      endcase
      r.error = sticky_err;
      pending.push_back(r);
      return r;
    endfunction

    function void check_result(tsrsm_pkg::out_t got);
      tsrsm_pkg::out_t exp;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.move !== exp.move) begin
        $error("move: expected %0d, actual %0d", exp.move, got.move);
        errors++;
      end
      if (got.done_res !== exp.done_res) begin
        $error("done_res: expected %0d, actual %0d", exp.done_res, got.done_res);
        errors++;
      end
      if (got.error !== exp.error) begin
        $error("error: expected %0d, actual %0d", exp.error, got.error);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 40000;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  tsrsm_pkg::in_t in_data = '0;
  logic out_valid;
  tsrsm_pkg::out_t out_data;

  move_scoreboard sb = new();
  int sent = 0;
  int idle_cycles = 0;
  bit gaps_on = 1;

  two_stack_radix_sort_moves_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // drives one beat, returns its predicted result; start is left high when it returns
  task automatic send(input logic [1:0] fn, input logic [VB-1:0] val,
                      output tsrsm_pkg::out_t r);
    int gap;
    gap = gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    start <= 1;
    in_data <= '{func: fn, value: val};
    do @(posedge clk); while (busy);
    r = sb.note_command('{func: fn, value: val});
    sent++;
    @(negedge clk);
  endtask

  // clears, loads the list, fetches until done and once more, may add a load or spare
  task automatic sort_list(input int n, input bit narrow);
    tsrsm_pkg::out_t r;
    logic [VB-1:0] v;
    send(tsrsm_pkg::FN_CLEAR, $urandom, r);
    for (int i = 0; i < n; i++) begin
      v = narrow ? $urandom_range(0, 3 * n) - n : $urandom;
      send(tsrsm_pkg::FN_LOAD, v, r);
    end
    do send(tsrsm_pkg::FN_FETCH, $urandom, r); while (!r.done_res);
    send(tsrsm_pkg::FN_FETCH, $urandom, r);
    if ($urandom_range(0, 3) == 0) send(tsrsm_pkg::FN_LOAD, $urandom, r);
    if ($urandom_range(0, 3) == 0) send(tsrsm_pkg::FN_SPARE, $urandom, r);
  endtask

  initial begin
    tsrsm_pkg::out_t r;
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // empty list fetch, extremes, unused code before and after the sort
    send(tsrsm_pkg::FN_FETCH, 0, r);
    send(tsrsm_pkg::FN_CLEAR, 0, r);
    send(tsrsm_pkg::FN_LOAD, 32'h8000_0000, r);
    send(tsrsm_pkg::FN_LOAD, 32'h7fff_ffff, r);
    send(tsrsm_pkg::FN_LOAD, 32'h0000_0000, r);
    send(tsrsm_pkg::FN_LOAD, 32'hffff_ffff, r);
    send(tsrsm_pkg::FN_SPARE, 32'h5a5a_5a5a, r);
    do send(tsrsm_pkg::FN_FETCH, 0, r); while (!r.done_res);
    send(tsrsm_pkg::FN_SPARE, 0, r);
    send(tsrsm_pkg::FN_LOAD, 5, r);
    // three items: done at once
    send(tsrsm_pkg::FN_CLEAR, 0, r);
    send(tsrsm_pkg::FN_LOAD, 1, r);
    send(tsrsm_pkg::FN_LOAD, 2, r);
    send(tsrsm_pkg::FN_LOAD, 3, r);
    send(tsrsm_pkg::FN_FETCH, 0, r);
    // duplicate sets the error, fetch then refuses
    send(tsrsm_pkg::FN_CLEAR, 0, r);
    send(tsrsm_pkg::FN_LOAD, 7, r);
    send(tsrsm_pkg::FN_LOAD, 7, r);
    send(tsrsm_pkg::FN_FETCH, 0, r);
    send(tsrsm_pkg::FN_LOAD, 8, r);
    // one load past capacity
    send(tsrsm_pkg::FN_CLEAR, 0, r);
    for (int i = 0; i <= NMAX; i++) send(tsrsm_pkg::FN_LOAD, i * 977 - 3000, r);
    send(tsrsm_pkg::FN_FETCH, 0, r);
    sort_list(NMAX, 0);

    while (sent < 1650) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 11) == 0) sort_list(NMAX, $urandom_range(0, 7) == 0);
      else sort_list($urandom_range(1, 20), $urandom_range(0, 7) == 0);
    end
    start <= 0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+src
src/tsrsm_pkg.sv
src/two_stack_radix_sort_moves_unit.sv
src/tsrsm_checker.sv
test/testbench.sv
